// ===== sv/moesi_pkg.sv =====
// ----------------------------------------------------------------------------
// moesi_pkg
// Types and constants shared by the MOESI snoop coherence controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package moesi_pkg;

    // Field widths fixed by the message format
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned LINE_W  = 8;
    localparam int unsigned NODE_W  = 4;
    localparam int unsigned STATE_W = 4;

    // Number of distinct line_index codes
    localparam int unsigned LINE_CODES = 256;

    // Message kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 3'd0,
        MODE_STORE = 3'd1,
        MODE_GETS  = 3'd2,
        MODE_GETM  = 3'd3,
        MODE_DATA  = 3'd4
    } mode_t;

    // Stable and transient line states
    typedef enum logic [STATE_W-1:0] {
        ST_I  = 4'd0,
        ST_S  = 4'd1,
        ST_E  = 4'd2,
        ST_O  = 4'd3,
        ST_M  = 4'd4,
        ST_IS = 4'd5,
        ST_IM = 4'd6,
        ST_SM = 4'd7,
        ST_OM = 4'd8
    } line_state_t;

    // Incoming coherence message
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LINE_W-1:0] line_index;
        logic [NODE_W-1:0] requester_id;
        logic              shared_seen;
    } req_t;

    // Action set produced for one message
    typedef struct packed {
        logic [LINE_W-1:0]  line_echo;
        logic               issue_gets;
        logic               issue_getm;
        logic               give_to_processor;
        logic               drive_bus_data;
        logic [NODE_W-1:0]  data_target;
        logic               assert_shared;
        logic               miss_event;
        logic               upgrade_event;
        logic               protocol_error;
        logic [STATE_W-1:0] new_line_state;
    } rsp_t;

    // Flags from the transition logic to the datapath
    typedef struct packed {
        logic        issue_gets;
        logic        issue_getm;
        logic        give_proc;
        logic        drive_bus;
        logic        assert_shared;
        logic        miss;
        logic        upgrade;
        logic        error;
        line_state_t next_state;
    } act_t;

endpackage

// ===== sv/moesi_if.sv =====
// ----------------------------------------------------------------------------
// moesi_req_if / moesi_rsp_if
// Valid/ready channels for coherence messages and their action sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface moesi_req_if;
    logic              valid;
    logic              ready;
    moesi_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface moesi_rsp_if;
    logic              valid;
    logic              ready;
    moesi_pkg::rsp_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/moesi_line_ram.sv =====
// ----------------------------------------------------------------------------
// moesi_line_ram
// Line state store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moesi_line_ram #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [ADDR_W-1:0]               wr_addr,
    input  logic [moesi_pkg::STATE_W-1:0]   wr_data,
    input  logic                            rd_en,
    input  logic [ADDR_W-1:0]               rd_addr,
    output logic [moesi_pkg::STATE_W-1:0]   rd_data
);

    logic [moesi_pkg::STATE_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/moesi_next_state.sv =====
// ----------------------------------------------------------------------------
// moesi_next_state
// MOESI transition table: message kind and current state to actions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moesi_next_state (
    input  logic [moesi_pkg::MODE_W-1:0]  mode,
    input  moesi_pkg::line_state_t        cur_state,
    input  logic                          shared_seen,
    output moesi_pkg::act_t               act
);

    logic store;

    assign store = (mode == moesi_pkg::MODE_STORE);

    always_comb
    begin
        act            = '0;
        act.next_state = cur_state;
        unique case (moesi_pkg::mode_t'(mode)) inside
            moesi_pkg::MODE_LOAD, moesi_pkg::MODE_STORE:
            begin
                // processor side; transients ignore the request
                unique case (cur_state)
                    moesi_pkg::ST_I:
                    begin
                        act.miss = 1'b1;
                        if (store)
                        begin
                            act.issue_getm = 1'b1;
                            act.next_state = moesi_pkg::ST_IM;
                        end
                        else
                        begin
                            act.issue_gets = 1'b1;
                            act.next_state = moesi_pkg::ST_IS;
                        end
                    end
                    moesi_pkg::ST_S:
                    begin
                        if (store)
                        begin
                            act.issue_getm = 1'b1;
                            act.miss       = 1'b1;
                            act.next_state = moesi_pkg::ST_SM;
                        end
                        else
                        begin
                            act.give_proc = 1'b1;
                        end
                    end
                    moesi_pkg::ST_E:
                    begin
                        act.give_proc = 1'b1;
                        if (store)
                        begin
                            act.upgrade    = 1'b1;
                            act.next_state = moesi_pkg::ST_M;
                        end
                    end
                    moesi_pkg::ST_O:
                    begin
                        if (store)
                        begin
                            act.issue_getm = 1'b1;
                            act.miss       = 1'b1;
                            act.next_state = moesi_pkg::ST_OM;
                        end
                        else
                        begin
                            act.give_proc = 1'b1;
                        end
                    end
                    moesi_pkg::ST_M:
                    begin
                        act.give_proc = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            moesi_pkg::MODE_GETS:
            begin
                unique case (cur_state) inside
                    moesi_pkg::ST_S, moesi_pkg::ST_SM:
                    begin
                        act.assert_shared = 1'b1;
                    end
                    moesi_pkg::ST_E:
                    begin
                        act.assert_shared = 1'b1;
                        act.drive_bus     = 1'b1;
                        act.next_state    = moesi_pkg::ST_S;
                    end
                    moesi_pkg::ST_O, moesi_pkg::ST_OM:
                    begin
                        act.assert_shared = 1'b1;
                        act.drive_bus     = 1'b1;
                    end
                    moesi_pkg::ST_M:
                    begin
                        act.assert_shared = 1'b1;
                        act.drive_bus     = 1'b1;
                        act.next_state    = moesi_pkg::ST_O;
                    end
                    default:
                    begin
                    end
                endcase
            end
            moesi_pkg::MODE_GETM:
            begin
                unique case (cur_state) inside
                    moesi_pkg::ST_S:
                    begin
                        act.next_state = moesi_pkg::ST_I;
                    end
                    moesi_pkg::ST_SM:
                    begin
                        act.next_state = moesi_pkg::ST_IM;
                    end
                    moesi_pkg::ST_E, moesi_pkg::ST_O, moesi_pkg::ST_M:
                    begin
                        act.drive_bus  = 1'b1;
                        act.next_state = moesi_pkg::ST_I;
                    end
                    moesi_pkg::ST_OM:
                    begin
                        act.drive_bus  = 1'b1;
                        act.next_state = moesi_pkg::ST_IM;
                    end
                    default:
                    begin
                    end
                endcase
            end
            moesi_pkg::MODE_DATA:
            begin
                unique case (cur_state) inside
                    moesi_pkg::ST_IS:
                    begin
                        act.give_proc  = 1'b1;
                        act.next_state = shared_seen ? moesi_pkg::ST_S : moesi_pkg::ST_E;
                    end
                    moesi_pkg::ST_IM, moesi_pkg::ST_SM, moesi_pkg::ST_OM:
                    begin
                        act.give_proc  = 1'b1;
                        act.next_state = moesi_pkg::ST_M;
                    end
                    moesi_pkg::ST_M:
                    begin
                        act.error = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                // undefined message kind
                act.error = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/moesi_snoop_coherence_controller.sv =====
// ----------------------------------------------------------------------------
// moesi_snoop_coherence_controller
// Snooping MOESI controller with one state per cache line. It takes one
// load, store or snooped GETS/GETM/DATA message per cycle and returns one
// action set per message, in order. A message is looked up in the line
// state RAM when it is transferred; the RAM's registered read feeds the
// result register, which holds the action set until the result side
// takes it. Back-to-back messages to the same line are served by
// forwarding the last write. Sustained rate is one message per cycle
// while the result side keeps up. After reset the controller sweeps the
// RAM to I, one line per cycle, and holds req.ready low until the sweep
// is done. line_index is reduced modulo NUM_LINES to select the entry;
// line_echo returns it unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moesi_snoop_coherence_controller #(
    parameter int unsigned NUM_LINES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    moesi_req_if.sink         req,
    moesi_rsp_if.source       rsp
);

    localparam int unsigned SLOT_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    // Line code to RAM slot, worked out at elaboration
    logic [SLOT_W-1:0] slot_tab [moesi_pkg::LINE_CODES];

    for (genvar g = 0; g < moesi_pkg::LINE_CODES; g++)
    begin : g_slot
        localparam int unsigned SLOT_VAL = g % NUM_LINES;
        assign slot_tab[g] = SLOT_W'(SLOT_VAL);
    end

    // Clearing sweep
    logic              clr_active_reg, clr_active_next;
    logic [SLOT_W-1:0] clr_cnt_reg,    clr_cnt_next;

    // Lookup stage
    logic              s1_valid_reg,   s1_valid_next;
    moesi_pkg::req_t   s1_item_reg;
    logic [SLOT_W-1:0] s1_slot_reg;

    // Last write, for same-line forwarding
    logic                            fwd_valid_reg;
    logic [SLOT_W-1:0]               fwd_slot_reg;
    logic [moesi_pkg::STATE_W-1:0]   fwd_state_reg;

    // Result register
    logic              out_valid_reg, out_valid_next;
    moesi_pkg::rsp_t   out_reg,       out_next;

    logic                            accept;
    logic                            advance;
    logic [SLOT_W-1:0]               in_slot;
    logic                            wr_en;
    logic [SLOT_W-1:0]               wr_addr;
    logic [moesi_pkg::STATE_W-1:0]   wr_data;
    logic [moesi_pkg::STATE_W-1:0]   rd_data;
    moesi_pkg::line_state_t          cur_state;
    moesi_pkg::act_t                 act;

    // Handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clr_active_reg && (!s1_valid_reg || advance);
    assign accept    = req.valid && req.ready;
    assign in_slot   = slot_tab[req.payload.line_index];

    // RAM write: sweep first, then write-back of the looked-up line
    assign wr_en   = clr_active_reg || advance;
    assign wr_addr = clr_active_reg ? clr_cnt_reg : s1_slot_reg;
    assign wr_data = clr_active_reg ? moesi_pkg::STATE_W'(moesi_pkg::ST_I)
                                    : moesi_pkg::STATE_W'(act.next_state);

    moesi_line_ram #(
        .DEPTH  (NUM_LINES),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (in_slot),
        .rd_data (rd_data)
    );

    // Current state, bypassing a write that collided with the read
    assign cur_state = moesi_pkg::line_state_t'(
        (fwd_valid_reg && (fwd_slot_reg == s1_slot_reg)) ? fwd_state_reg : rd_data);

    moesi_next_state u_next (
        .mode        (s1_item_reg.mode),
        .cur_state   (cur_state),
        .shared_seen (s1_item_reg.shared_seen),
        .act         (act)
    );

    // Next-value logic for control and result
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            if (clr_cnt_reg == SLOT_W'(NUM_LINES - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end

        s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

        out_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

        out_next                   = out_reg;
        out_next.line_echo         = s1_item_reg.line_index;
        out_next.issue_gets        = act.issue_gets;
        out_next.issue_getm        = act.issue_getm;
        out_next.give_to_processor = act.give_proc;
        out_next.drive_bus_data    = act.drive_bus;
        out_next.data_target       = act.drive_bus ? s1_item_reg.requester_id : '0;
        out_next.assert_shared     = act.assert_shared;
        out_next.miss_event        = act.miss;
        out_next.upgrade_event     = act.upgrade;
        out_next.protocol_error    = act.error;
        out_next.new_line_state    = moesi_pkg::STATE_W'(act.next_state);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= req.payload;
            s1_slot_reg <= in_slot;
        end
        if (wr_en)
        begin
            fwd_slot_reg  <= wr_addr;
            fwd_state_reg <= wr_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // Checks
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s1_valid_reg && !out_valid_reg))
        else $error("item in flight during clearing sweep");

    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && act.error) |-> (act.next_state == cur_state))
        else $error("illegal message changed line state");

    a_upgrade_e_to_m: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && act.upgrade) |->
        (cur_state == moesi_pkg::ST_E && act.next_state == moesi_pkg::ST_M))
        else $error("upgrade outside E to M");

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !clr_active_reg) |=>
        (fwd_valid_reg && fwd_slot_reg == $past(s1_slot_reg)
         && fwd_state_reg == $past(out_next.new_line_state)))
        else $error("write-back not captured for forwarding");

    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.drive_bus_data || out_reg.data_target == '0))
        else $error("data target set without bus data");

endmodule
